FILE: rtl/stoc_pkg.sv
// ----------------------------------------------------------------------------
// stoc_pkg: shared types and constants
// Error codes, configuration register indexes and the tag that travels with
// each request from the front queue to the back end.
// ----------------------------------------------------------------------------
package stoc_pkg;

    localparam int COORD_W    = 32;
    localparam int WIDTH_W    = 16;
    localparam int TILE_CNT_W = 13;
    localparam int PROD_W     = TILE_CNT_W + WIDTH_W;
    localparam int CAP_W      = PROD_W + WIDTH_W;

    localparam logic [WIDTH_W-1:0]    RESET_TILE_SIZE  = 16'd16;
    localparam logic [COORD_W-1:0]    RESET_MATRIX_DIM = 32'd1;
    localparam logic [TILE_CNT_W-1:0] TILE_CNT_MAX     = '1;
    localparam logic [COORD_W-1:0]    ENTRY_CNT_MAX    = '1;

    // configuration register indexes
    localparam logic [1:0] CFG_TILE_SIZE      = 2'd0;
    localparam logic [1:0] CFG_MATRIX_ROWS    = 2'd1;
    localparam logic [1:0] CFG_MATRIX_COLUMNS = 2'd2;

    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_BOUNDS   = 2'd1,
        ERR_GRID     = 2'd2,
        ERR_CAPACITY = 2'd3
    } err_t;

    typedef struct packed {
        err_t code;
        logic last;
    } stoc_tag_t;

endpackage

FILE: rtl/stoc_div.sv
// ----------------------------------------------------------------------------
// stoc_div: iterative tile index divider
// Restoring division, one quotient bit per cycle. The dividend is known to be
// below divisor * 2^QW, so QW steps give the full quotient.
// ----------------------------------------------------------------------------
module stoc_div
    import stoc_pkg::*;
#(
    parameter int QW = 6,
    parameter int DW = WIDTH_W + QW
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [DW-1:0]      dividend,
    input  logic [WIDTH_W-1:0] divisor,
    output logic               ready,
    output logic [QW-1:0]      quotient
);

    localparam int CNT_W = $clog2(QW + 1);

    logic [DW-1:0]    rem_reg, rem_next;
    logic [DW-1:0]    dsr_reg, dsr_next;
    logic [QW-1:0]    quo_reg, quo_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             ge;

    always_comb
    begin
        ge       = (rem_reg >= dsr_reg);
        rem_next = rem_reg;
        dsr_next = dsr_reg;
        quo_next = quo_reg;
        cnt_next = cnt_reg;
        if (start)
        begin
            rem_next = dividend;
            dsr_next = DW'(divisor) << (QW - 1);
            quo_next = '0;
            cnt_next = CNT_W'(QW);
        end
        else if (cnt_reg != '0)
        begin
            rem_next = ge ? (rem_reg - dsr_reg) : rem_reg;
            dsr_next = dsr_reg >> 1;
            quo_next = QW'({quo_reg, ge});
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        quo_reg <= quo_next;
    end

    assign ready    = (cnt_reg == '0);
    assign quotient = quo_reg;

endmodule

FILE: rtl/stoc_front.sv
// ----------------------------------------------------------------------------
// stoc_front: request intake and classification
// Checks each coordinate against the matrix size, the tile width and the
// tile grid, and queues the zero-based coordinates with their error tag.
// ----------------------------------------------------------------------------
module stoc_front
    import stoc_pkg::*;
#(
    parameter int DW = 22
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [COORD_W-1:0] row_index,
    input  logic [COORD_W-1:0] column_index,
    input  logic               last_entry,
    input  logic [WIDTH_W-1:0] tile_size,
    input  logic [COORD_W-1:0] matrix_rows,
    input  logic [COORD_W-1:0] matrix_columns,
    input  logic [DW-1:0]      row_limit,
    input  logic [DW-1:0]      col_limit,
    input  logic               clearing,
    output logic               q_valid,
    output stoc_tag_t          q_tag,
    output logic [DW-1:0]      q_row0,
    output logic [DW-1:0]      q_col0,
    input  logic               q_take
);

    localparam int QDEPTH = 2;

    stoc_tag_t   tag_reg  [QDEPTH];
    logic [DW-1:0] row0_reg [QDEPTH];
    logic [DW-1:0] col0_reg [QDEPTH];
    logic [1:0]  count_reg, count_next;
    logic        wr_ptr_reg, rd_ptr_reg;
    logic        push_ok;
    logic        bad_bounds;
    logic        bad_grid;
    stoc_tag_t   in_tag;

    always_comb
    begin
        bad_bounds = (row_index == '0) || (row_index > matrix_rows) ||
                     (column_index == '0) || (column_index > matrix_columns);
        // row-1 >= limit is the same as row > limit for row >= 1
        bad_grid   = (row_index > COORD_W'(row_limit)) ||
                     (column_index > COORD_W'(col_limit));
        in_tag.last = last_entry;
        if (bad_bounds)
            in_tag.code = ERR_BOUNDS;
        else if (tile_size == '0)
            in_tag.code = ERR_CAPACITY;
        else if (bad_grid)
            in_tag.code = ERR_GRID;
        else
            in_tag.code = ERR_NONE;
    end

    assign full    = (count_reg == 2'(QDEPTH)) || clearing;
    assign push_ok = push && !full;

    always_comb
    begin
        count_next = count_reg;
        if (push_ok && !q_take)
            count_next = count_reg + 2'd1;
        else if (!push_ok && q_take)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (push_ok)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (q_take)
                rd_ptr_reg <= ~rd_ptr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            tag_reg[wr_ptr_reg]  <= in_tag;
            row0_reg[wr_ptr_reg] <= DW'(row_index - COORD_W'(1));
            col0_reg[wr_ptr_reg] <= DW'(column_index - COORD_W'(1));
        end
    end

    assign q_valid = (count_reg != '0);
    assign q_tag   = tag_reg[rd_ptr_reg];
    assign q_row0  = row0_reg[rd_ptr_reg];
    assign q_col0  = col0_reg[rd_ptr_reg];

endmodule

FILE: rtl/stoc_back.sv
// ----------------------------------------------------------------------------
// stoc_back: census engine
// Divides queued coordinates into a tile cell, marks the bitmap, keeps the
// counters and sticky error, builds the report and sweeps the bitmap clear.
// ----------------------------------------------------------------------------
module stoc_back
    import stoc_pkg::*;
#(
    parameter int TILE_GRID_ROWS = 64,
    parameter int TILE_GRID_COLS = 64,
    parameter int QW = 6,
    parameter int DW = WIDTH_W + QW,
    parameter int CELLS = TILE_GRID_ROWS * TILE_GRID_COLS,
    parameter int CW = (CELLS > 1) ? $clog2(CELLS) : 1
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_valid,
    input  stoc_tag_t             q_tag,
    input  logic [DW-1:0]         q_row0,
    input  logic [DW-1:0]         q_col0,
    output logic                  q_take,
    output logic                  clearing,
    input  logic [WIDTH_W-1:0]    tile_size,
    output logic                  empty,
    input  logic                  pop,
    output logic [COORD_W-1:0]    entry_count,
    output logic [TILE_CNT_W-1:0] occupied_tile_count,
    output logic                  qualified,
    output logic [1:0]            error_code
);

    typedef enum logic [7:0] {
        ST_CLEAR  = 8'b0000_0001,
        ST_IDLE   = 8'b0000_0010,
        ST_DIV    = 8'b0000_0100,
        ST_LOOK   = 8'b0000_1000,
        ST_MARK   = 8'b0001_0000,
        ST_CAP1   = 8'b0010_0000,
        ST_CAP2   = 8'b0100_0000,
        ST_REPORT = 8'b1000_0000
    } state_t;

    state_t                state_reg, state_next;
    logic [CW-1:0]         clr_reg, clr_next;
    logic [CW-1:0]         cell_reg, cell_next;
    logic                  last_reg, last_next;
    logic [COORD_W-1:0]    entry_reg, entry_next;
    logic [TILE_CNT_W-1:0] tile_reg, tile_next;
    err_t                  sticky_reg, sticky_next;
    logic [PROD_W-1:0]     prod_reg, prod_next;
    logic [CAP_W-1:0]      cap_reg, cap_next;
    logic                  out_valid_reg, out_valid_next;
    logic [COORD_W-1:0]    out_entry_reg;
    logic [TILE_CNT_W-1:0] out_tile_reg;
    logic                  out_qual_reg;
    err_t                  out_err_reg;

    logic                  bitmap_mem [CELLS];
    logic                  rd_reg;
    logic                  mem_we;
    logic [CW-1:0]         mem_addr;
    logic                  mem_wbit;

    logic                  div_start;
    logic                  row_ready, col_ready;
    logic [QW-1:0]         row_quo, col_quo;
    logic                  out_load;
    err_t                  rep_err;
    logic                  rep_qual;

    stoc_div #(.QW(QW), .DW(DW)) u_row_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (q_row0),
        .divisor  (tile_size),
        .ready    (row_ready),
        .quotient (row_quo)
    );

    stoc_div #(.QW(QW), .DW(DW)) u_col_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (q_col0),
        .divisor  (tile_size),
        .ready    (col_ready),
        .quotient (col_quo)
    );

    assign q_take    = (state_reg == ST_IDLE) && q_valid;
    assign div_start = q_take && (q_tag.code == ERR_NONE);
    assign clearing  = (state_reg == ST_CLEAR);
    assign out_load  = (state_reg == ST_REPORT) && (!out_valid_reg || pop);

    // report: a clean census still fails when capacity is zero or too small
    always_comb
    begin
        if (sticky_reg != ERR_NONE)
            rep_err = sticky_reg;
        else if ((cap_reg == '0) || (CAP_W'(entry_reg) > cap_reg))
            rep_err = ERR_CAPACITY;
        else
            rep_err = ERR_NONE;
        rep_qual = (rep_err == ERR_NONE) && (CAP_W'({entry_reg, 1'b0}) >= cap_reg);
    end

    always_comb
    begin
        mem_we   = 1'b0;
        mem_addr = cell_reg;
        mem_wbit = 1'b1;
        case (state_reg)
            ST_CLEAR:
            begin
                mem_we   = 1'b1;
                mem_addr = clr_reg;
                mem_wbit = 1'b0;
            end
            ST_MARK:
            begin
                mem_we = !rd_reg;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        cell_next   = cell_reg;
        last_next   = last_reg;
        entry_next  = entry_reg;
        tile_next   = tile_reg;
        sticky_next = sticky_reg;
        prod_next   = prod_reg;
        cap_next    = cap_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                clr_next = clr_reg + CW'(1);
                if (clr_reg == CW'(CELLS - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (q_take)
                begin
                    last_next = q_tag.last;
                    if (q_tag.code != ERR_NONE)
                    begin
                        if (sticky_reg == ERR_NONE)
                            sticky_next = q_tag.code;
                        state_next = q_tag.last ? ST_CAP1 : ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                if (row_ready && col_ready)
                begin
                    cell_next  = CW'(CW'(row_quo) * CW'(TILE_GRID_COLS) + CW'(col_quo));
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                state_next = ST_MARK;
            end
            ST_MARK:
            begin
                if (!rd_reg && (tile_reg != TILE_CNT_MAX))
                    tile_next = tile_reg + TILE_CNT_W'(1);
                if (entry_reg != ENTRY_CNT_MAX)
                    entry_next = entry_reg + COORD_W'(1);
                state_next = last_reg ? ST_CAP1 : ST_IDLE;
            end
            ST_CAP1:
            begin
                prod_next  = PROD_W'(tile_reg) * PROD_W'(tile_size);
                state_next = ST_CAP2;
            end
            ST_CAP2:
            begin
                cap_next   = CAP_W'(prod_reg) * CAP_W'(tile_size);
                state_next = ST_REPORT;
            end
            ST_REPORT:
            begin
                if (out_load)
                begin
                    entry_next  = '0;
                    tile_next   = '0;
                    sticky_next = ERR_NONE;
                    clr_next    = '0;
                    state_next  = ST_CLEAR;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
                clr_next   = '0;
            end
        endcase
    end

    assign out_valid_next = out_load || (out_valid_reg && !pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            last_reg      <= 1'b0;
            entry_reg     <= '0;
            tile_reg      <= '0;
            sticky_reg    <= ERR_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            last_reg      <= last_next;
            entry_reg     <= entry_next;
            tile_reg      <= tile_next;
            sticky_reg    <= sticky_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cell_reg <= cell_next;
        prod_reg <= prod_next;
        cap_reg  <= cap_next;
        if (out_load)
        begin
            out_entry_reg <= entry_reg;
            out_tile_reg  <= tile_reg;
            out_qual_reg  <= rep_qual;
            out_err_reg   <= rep_err;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            bitmap_mem[mem_addr] <= mem_wbit;
        rd_reg <= bitmap_mem[cell_reg];
    end

    assign empty               = !out_valid_reg;
    assign entry_count         = out_entry_reg;
    assign occupied_tile_count = out_tile_reg;
    assign qualified           = out_qual_reg;
    assign error_code          = out_err_reg;

`ifndef SYNTHESIS
    a_take_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_take |-> (state_reg == ST_IDLE))
        else $error("request taken outside idle");

    a_new_tile_counted: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MARK) && !rd_reg && (tile_reg != TILE_CNT_MAX)
        |=> tile_reg == TILE_CNT_W'($past(tile_reg) + TILE_CNT_W'(1)))
        else $error("new tile not counted");

    a_tiles_within_entries: assert property (@(posedge clk) disable iff (!rst_n)
        (entry_reg < COORD_W'(TILE_CNT_MAX)) |-> (COORD_W'(tile_reg) <= entry_reg))
        else $error("more tiles than entries");

    a_report_clears: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (entry_reg == '0) && (tile_reg == '0) && (sticky_reg == ERR_NONE)
                     && (state_reg == ST_CLEAR))
        else $error("census not cleared after report");
`endif

endmodule

FILE: rtl/sparse_tile_occupancy_census.sv
// ----------------------------------------------------------------------------
// sparse_tile_occupancy_census: tile occupancy count of a sparse matrix
// Configuration registers, grid limits, and the front and back halves.
// ----------------------------------------------------------------------------
// Each request carries one 1-based (row, column) of a nonzero entry. The front
// checks it and queues it (two deep); the back divides the zero-based
// coordinates by the tile width with two bit-serial dividers, marks the tile
// in a bitmap and counts. A valid entry passes the divide, look-up and mark
// states; Q = clog2(max(TILE_GRID_ROWS, TILE_GRID_COLS)) is the divider step
// count. A rejected entry skips the dividers and the bitmap. The entry with
// last_entry set then passes the capacity product states and the report
// state, which queues one result. After reset and after every result the
// bitmap is swept clear, one cell per cycle, over all TILE_GRID_ROWS *
// TILE_GRID_COLS cells (4096 by default); full stays high during the sweep.
// Configuration may be written while the block holds no pending request.
// ----------------------------------------------------------------------------
module sparse_tile_occupancy_census
    import stoc_pkg::*;
#(
    parameter int TILE_GRID_ROWS = 64,
    parameter int TILE_GRID_COLS = 64
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [COORD_W-1:0]    cfg_data,
    input  logic                  push,
    output logic                  full,
    input  logic [COORD_W-1:0]    row_index,
    input  logic [COORD_W-1:0]    column_index,
    input  logic                  last_entry,
    output logic                  empty,
    input  logic                  pop,
    output logic [COORD_W-1:0]    entry_count,
    output logic [TILE_CNT_W-1:0] occupied_tile_count,
    output logic                  qualified,
    output logic [1:0]            error_code
);

    localparam int GRID_MAX = (TILE_GRID_ROWS > TILE_GRID_COLS) ? TILE_GRID_ROWS
                                                                : TILE_GRID_COLS;
    localparam int QW    = (GRID_MAX > 1) ? $clog2(GRID_MAX) : 1;
    localparam int DW    = WIDTH_W + QW;
    localparam int CELLS = TILE_GRID_ROWS * TILE_GRID_COLS;
    localparam int CW    = (CELLS > 1) ? $clog2(CELLS) : 1;

    logic [WIDTH_W-1:0] tile_size_reg;
    logic [COORD_W-1:0] matrix_rows_reg;
    logic [COORD_W-1:0] matrix_columns_reg;
    logic [DW-1:0]      row_limit_reg;
    logic [DW-1:0]      col_limit_reg;

    logic               q_valid;
    stoc_tag_t          q_tag;
    logic [DW-1:0]      q_row0;
    logic [DW-1:0]      q_col0;
    logic               q_take;
    logic               clearing;

    // grid limits (grid size * tile width) follow the tile width write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tile_size_reg      <= RESET_TILE_SIZE;
            matrix_rows_reg    <= RESET_MATRIX_DIM;
            matrix_columns_reg <= RESET_MATRIX_DIM;
            row_limit_reg      <= DW'(DW'(TILE_GRID_ROWS) * DW'(RESET_TILE_SIZE));
            col_limit_reg      <= DW'(DW'(TILE_GRID_COLS) * DW'(RESET_TILE_SIZE));
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_TILE_SIZE:
                begin
                    tile_size_reg <= cfg_data[WIDTH_W-1:0];
                    row_limit_reg <= DW'(DW'(TILE_GRID_ROWS) * DW'(cfg_data[WIDTH_W-1:0]));
                    col_limit_reg <= DW'(DW'(TILE_GRID_COLS) * DW'(cfg_data[WIDTH_W-1:0]));
                end
                CFG_MATRIX_ROWS:
                begin
                    matrix_rows_reg <= cfg_data;
                end
                CFG_MATRIX_COLUMNS:
                begin
                    matrix_columns_reg <= cfg_data;
                end
                default:
                begin
                    tile_size_reg <= tile_size_reg;
                end
            endcase
        end
    end

    stoc_front #(.DW(DW)) u_front
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .row_index      (row_index),
        .column_index   (column_index),
        .last_entry     (last_entry),
        .tile_size      (tile_size_reg),
        .matrix_rows    (matrix_rows_reg),
        .matrix_columns (matrix_columns_reg),
        .row_limit      (row_limit_reg),
        .col_limit      (col_limit_reg),
        .clearing       (clearing),
        .q_valid        (q_valid),
        .q_tag          (q_tag),
        .q_row0         (q_row0),
        .q_col0         (q_col0),
        .q_take         (q_take)
    );

    stoc_back #(
        .TILE_GRID_ROWS (TILE_GRID_ROWS),
        .TILE_GRID_COLS (TILE_GRID_COLS),
        .QW             (QW),
        .DW             (DW),
        .CELLS          (CELLS),
        .CW             (CW)
    ) u_back
    (
        .clk                 (clk),
        .rst_n               (rst_n),
        .q_valid             (q_valid),
        .q_tag               (q_tag),
        .q_row0              (q_row0),
        .q_col0              (q_col0),
        .q_take              (q_take),
        .clearing            (clearing),
        .tile_size           (tile_size_reg),
        .empty               (empty),
        .pop                 (pop),
        .entry_count         (entry_count),
        .occupied_tile_count (occupied_tile_count),
        .qualified           (qualified),
        .error_code          (error_code)
    );

endmodule

FILE: tb/tb_sparse_tile_occupancy_census.sv
// ----------------------------------------------------------------------------
// tb_sparse_tile_occupancy_census: self-checking testbench
// Drives coordinate requests through the push/full queue, predicts every
// census report in a scoreboard class and compares each popped report field
// by field. It starts with directed matrices, then runs random phases under
// varied register settings and idle patterns, including a long output stall.
// ----------------------------------------------------------------------------
module tb_sparse_tile_occupancy_census;
    import stoc_pkg::*;

    localparam int GRID_ROWS       = 64;
    localparam int GRID_COLS       = 64;
    localparam int GRID_CELLS      = GRID_ROWS * GRID_COLS;
    localparam int SETTLE_CYCLES   = 40;
    localparam int HOLD_CYCLES     = 10000;
    localparam int WATCHDOG_LIMIT  = 40000;
    localparam int PHASES          = 9;
    localparam int ITEMS_PER_PHASE = 92;
    localparam int MAX_SHOWN       = 10;

    typedef struct {
        logic [COORD_W-1:0]    entries;
        logic [TILE_CNT_W-1:0] tiles;
        logic                  qual;
        err_t                  code;
    } census_report_t;

    // Tracks the running census of the current matrix and the reports owed.
    class census_tracker;
        logic [WIDTH_W-1:0]    tile_span  = RESET_TILE_SIZE;
        logic [COORD_W-1:0]    rows       = RESET_MATRIX_DIM;
        logic [COORD_W-1:0]    cols       = RESET_MATRIX_DIM;
        bit                    occupied [GRID_CELLS];
        logic [COORD_W-1:0]    entries    = '0;
        logic [TILE_CNT_W-1:0] tiles      = '0;
        err_t                  held       = ERR_NONE;
        census_report_t        reports_due [$];
        int                    requests   = 0;
        int                    checked    = 0;
        int                    failures   = 0;

        function void set_config(logic [WIDTH_W-1:0] width, logic [COORD_W-1:0] r,
                                 logic [COORD_W-1:0] c);
            tile_span = width;
            rows      = r;
            cols      = c;
        endfunction

        function int pending();
            return reports_due.size();
        endfunction

        function void raise_error(err_t code);
            if (held == ERR_NONE)
                held = code;
        endfunction

        function void tally_entry(logic [COORD_W-1:0] row, logic [COORD_W-1:0] col,
                                  logic last);
            logic [COORD_W-1:0] trow;
            logic [COORD_W-1:0] tcol;
            logic [63:0]        capacity;
            int                 slot;
            census_report_t     r;

            requests++;
            if (row == 0 || row > rows || col == 0 || col > cols)
                raise_error(ERR_BOUNDS);
            else if (tile_span == 0)
                raise_error(ERR_CAPACITY);
            else
            begin
                trow = (row - 1) / tile_span;
                tcol = (col - 1) / tile_span;
                if (trow >= GRID_ROWS || tcol >= GRID_COLS)
                    raise_error(ERR_GRID);
                else
                begin
                    slot = int'(trow) * GRID_COLS + int'(tcol);
                    if (!occupied[slot])
                    begin
                        occupied[slot] = 1'b1;
                        if (tiles != TILE_CNT_MAX)
                            tiles++;
                    end
                    if (entries != ENTRY_CNT_MAX)
                        entries++;
                end
            end
            if (!last)
                return;

            capacity = 64'(tiles) * 64'(tile_span) * 64'(tile_span);
            if (held == ERR_NONE && (capacity == 0 || 64'(entries) > capacity))
                raise_error(ERR_CAPACITY);
            r.entries = entries;
            r.tiles   = tiles;
            r.code    = held;
            r.qual    = (held == ERR_NONE) && (64'(entries) * 2 >= capacity);
            reports_due = {reports_due, r};

            foreach (occupied[i])
                occupied[i] = 1'b0;
            entries = '0;
            tiles   = '0;
            held    = ERR_NONE;
        endfunction

        function void check_report(logic [COORD_W-1:0] cnt, logic [TILE_CNT_W-1:0] t,
                                   logic q, logic [1:0] code);
            census_report_t want;

            if (reports_due.size() == 0)
            begin
                failures++;
                if (failures <= MAX_SHOWN)
                    $display("unexpected report: entries=%0d tiles=%0d qual=%0b err=%0d",
                             cnt, t, q, code);
                return;
            end
            want = reports_due.pop_front();
            checked++;
            if (cnt !== want.entries || t !== want.tiles || q !== want.qual
                    || code !== want.code)
            begin
                failures++;
                if (failures <= MAX_SHOWN)
                    $display({"report %0d mismatch: want entries=%0d tiles=%0d qual=%0b",
                              " err=%0d, got entries=%0d tiles=%0d qual=%0b err=%0d"},
                             checked, want.entries, want.tiles, want.qual, want.code,
                             cnt, t, q, code);
            end
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [1:0]            cfg_index;
    logic [COORD_W-1:0]    cfg_data;
    logic                  push;
    logic                  full;
    logic [COORD_W-1:0]    row_index;
    logic [COORD_W-1:0]    column_index;
    logic                  last_entry;
    logic                  empty;
    logic                  pop;
    logic [COORD_W-1:0]    entry_count;
    logic [TILE_CNT_W-1:0] occupied_tile_count;
    logic                  qualified;
    logic [1:0]            error_code;

    census_tracker census = new;

    int                 tx_idle_pct = 0;
    int                 rx_idle_pct = 0;
    bit                 hold_req    = 1'b0;
    int                 settings    = 0;
    logic [WIDTH_W-1:0] cur_width   = RESET_TILE_SIZE;
    logic [COORD_W-1:0] cur_rows    = RESET_MATRIX_DIM;
    logic [COORD_W-1:0] cur_cols    = RESET_MATRIX_DIM;

    logic [WIDTH_W-1:0] phase_width [PHASES] = '{1, 16, 65535, 3, 1, 2, 7, 1, 255};
    logic [COORD_W-1:0] phase_rows  [PHASES] =
        '{64, 1024, 32'hFFFF_FFFF, 200, 1, 128, 500, 32'hFFFF_FFFF, 20000};
    logic [COORD_W-1:0] phase_cols  [PHASES] =
        '{64, 700, 32'hFFFF_FFFF, 150, 1, 128, 300, 40, 16320};

    sparse_tile_occupancy_census uut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cfg_we              (cfg_we),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .push                (push),
        .full                (full),
        .row_index           (row_index),
        .column_index        (column_index),
        .last_entry          (last_entry),
        .empty               (empty),
        .pop                 (pop),
        .entry_count         (entry_count),
        .occupied_tile_count (occupied_tile_count),
        .qualified           (qualified),
        .error_code          (error_code)
    );

    always #4 clk = ~clk;

    // Watchdog: cycles with no request moving on either side.
    int quiet_cycles = 0;
    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("timeout after %0d idle cycles", quiet_cycles);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Report side: check on each pop, then pick next pop level.
    int hold_left = 0;
    initial
    begin
        pop <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
                census.check_report(entry_count, occupied_tile_count, qualified, error_code);
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
                pop <= 1'b0;
            end
            else
                pop <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    task automatic send_entry(input logic [COORD_W-1:0] row, input logic [COORD_W-1:0] col,
                              input logic last);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push         <= 1'b1;
        row_index    <= row;
        column_index <= col;
        last_entry   <= last;
        @(posedge clk);
        while (full)
            @(posedge clk);
        census.tally_entry(row, col, last);
    endtask

    // Stop offering and wait for every owed report, then let the back settle.
    task automatic wait_quiet();
        push <= 1'b0;
        while (census.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [COORD_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
    endtask

    task automatic apply_setting(input logic [WIDTH_W-1:0] width,
                                 input logic [COORD_W-1:0] r, input logic [COORD_W-1:0] c);
        write_reg(CFG_TILE_SIZE, 32'(width));
        write_reg(CFG_MATRIX_ROWS, r);
        write_reg(CFG_MATRIX_COLUMNS, c);
        cfg_we <= 1'b0;
        census.set_config(width, r, c);
        cur_width = width;
        cur_rows  = r;
        cur_cols  = c;
        settings++;
    endtask

    // Coordinate in 1..dim; dense picks land within one tile width of base.
    // Spread picks mostly stay inside the grid reach.
    function automatic logic [COORD_W-1:0] pick_coord(logic [COORD_W-1:0] dim,
                                                      logic [COORD_W-1:0] base, bit dense);
        logic [63:0] reach;
        logic [63:0] c;

        reach = 64'(cur_width) * GRID_ROWS;
        if (reach > 64'(dim) || $urandom_range(0, 3) == 0)
            reach = 64'(dim);
        if (dense)
            c = 64'(base) + $urandom_range(0, 32'(cur_width) - 1);
        else
            c = 64'($urandom_range(1, reach[31:0]));
        if (c > 64'(dim))
            c = 64'(dim);
        return c[31:0];
    endfunction

    task automatic random_phase(input int items);
        int                 sent;
        int                 len;
        bit                 dense;
        logic [COORD_W-1:0] base_r;
        logic [COORD_W-1:0] base_c;
        logic [COORD_W-1:0] r;
        logic [COORD_W-1:0] c;

        sent = 0;
        while (sent < items)
        begin
            len    = $urandom_range(1, 20);
            if (len > items - sent)
                len = items - sent;
            dense  = ($urandom_range(0, 1) == 0);
            base_r = pick_coord(cur_rows, 0, 1'b0);
            base_c = pick_coord(cur_cols, 0, 1'b0);
            for (int k = 0; k < len; k++)
            begin
                r = pick_coord(cur_rows, base_r, dense);
                c = pick_coord(cur_cols, base_c, dense);
                if ($urandom_range(0, 99) < 8)
                begin
                    case ($urandom_range(0, 3))
                        0: r = '0;
                        1: c = '0;
                        2: r = $urandom;
                        default: c = $urandom;
                    endcase
                end
                send_entry(r, c, k == len - 1);
                sent++;
            end
        end
    endtask

    initial
    begin
        rst_n        <= 1'b0;
        cfg_we       <= 1'b0;
        cfg_index    <= CFG_TILE_SIZE;
        cfg_data     <= '0;
        push         <= 1'b0;
        row_index    <= '0;
        column_index <= '0;
        last_entry   <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        tx_idle_pct = 25;
        rx_idle_pct = 69;

        // reset register values: 16 wide tiles on a 1 x 1 matrix
        send_entry(1, 1, 1'b1);
        send_entry(0, 1, 1'b0);
        send_entry(1, 1, 1'b1);
        send_entry(1, 2, 1'b1);

        // zero tile width cannot place anything
        wait_quiet();
        apply_setting(0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_entry(5, 5, 1'b0);
        send_entry(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);

        // unit tiles on an exact 64 x 64 grid: corners, duplicate, out of bounds
        wait_quiet();
        apply_setting(1, 64, 64);
        send_entry(1, 1, 1'b0);
        send_entry(64, 64, 1'b0);
        send_entry(1, 64, 1'b1);
        send_entry(2, 2, 1'b0);
        send_entry(2, 2, 1'b1);
        send_entry(65, 1, 1'b1);

        // matrix larger than the grid; first error wins
        wait_quiet();
        apply_setting(1, 100, 100);
        send_entry(65, 1, 1'b0);
        send_entry(1, 1, 1'b1);
        send_entry(1, 1, 1'b0);
        send_entry(0, 0, 1'b0);
        send_entry(100, 1, 1'b0);
        send_entry(3, 3, 1'b1);

        // widest tiles, largest matrix: last grid row edge
        wait_quiet();
        apply_setting(16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_entry(32'hFFFF_FFFF, 1, 1'b0);
        send_entry(4194240, 4194240, 1'b1);
        send_entry(4194240, 1, 1'b1);
        send_entry(4194241, 1, 1'b1);

        // tile three quarters full qualifies
        wait_quiet();
        apply_setting(2, 8, 8);
        send_entry(1, 1, 1'b0);
        send_entry(2, 2, 1'b0);
        send_entry(1, 2, 1'b1);

        for (int p = 0; p < PHASES; p++)
        begin
            wait_quiet();
            if (p < 3)
            begin
                tx_idle_pct = 25;
                rx_idle_pct = 69;
            end
            else if (p < 6)
            begin
                tx_idle_pct = 69;
                rx_idle_pct = 25;
            end
            else
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            apply_setting(phase_width[p], phase_rows[p], phase_cols[p]);
            // long report-side stall while requests keep coming
            if (p == 6)
                hold_req = 1'b1;
            random_phase(ITEMS_PER_PHASE);
        end
        wait_quiet();

        $display("Summary: %0d coordinate requests under %0d register settings,",
                 census.requests, settings + 1);
        $display("Summary: %0d reports checked, %0d mismatches, %0d reports still owed",
                 census.checked, census.failures, census.pending());
        if (census.failures == 0 && census.pending() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

FILE: files.f
rtl/stoc_pkg.sv
rtl/stoc_div.sv
rtl/stoc_front.sv
rtl/stoc_back.sv
rtl/sparse_tile_occupancy_census.sv
tb/tb_sparse_tile_occupancy_census.sv
